[src/bsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the binary 2x2 square cover check unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int CFG_W     = 7;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 12;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;

  // configuration register indexes
  localparam logic CFG_IMAGE_ROWS = 1'b0;
  localparam logic CFG_IMAGE_COLS = 1'b1;

  // result kinds, carried on tuser
  localparam logic KIND_WINDOW  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   win_row;
    logic [POS_W-1:0]   win_col;
    logic               covered_ok;
    logic [COUNT_W-1:0] window_count;
    logic               last;
  } result_t;

endpackage

[src/binary_square_cover_check_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_square_cover_check_unit
// Streams a binary image in raster order, reports every all-ones 2x2 window
// and ends each image with a verdict on whether the windows cover all set
// pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and decides it in the cycle it is
// accepted; results go to a four-entry queue on the output side. A pixel
// that completes an all-ones window gives a window result, and the last
// pixel of the image also gives the verdict, so it can give two results.
// The input is ready while the queue holds at most two results, so with the
// output taking one result a clock the sustained rate is one pixel per
// clock. The row above is held in two one-bit line memories of MAX_SIDE
// entries (pixels and window flags), read one column ahead. Window
// positions are sent even when the verdict later fails. A write to either
// size register restarts the image; sizes are clamped to 2..MAX_SIDE.
// ----------------------------------------------------------------------------
module binary_square_cover_check_unit
  import bsc_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [0] pixel, [7:1] zero
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [5:0] win_row, [11:6] win_col,
                                          // [12] covered_ok, [24:13] window_count
  output logic [0:0]           m_tuser,   // [0] result_kind
  output logic                 m_tlast,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int AW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;

  function automatic logic [SW-1:0] clamp_side(input logic [CFG_W-1:0] v);
    if (int'(v) < 2) return SW'(2);
    else if (int'(v) > MAX_SIDE) return SW'(MAX_SIDE);
    else return SW'(v);
  endfunction

  // size and position
  logic [SW-1:0]      rows_lim;
  logic [SW-1:0]      cols_lim;
  logic [SW-1:0]      row_cnt;
  logic [SW-1:0]      col_cnt;
  logic [COUNT_W-1:0] found_cnt;
  logic               fail;

  // neighborhood registers
  logic left_pix;    // pixel to the left in this row
  logic above_left;  // row above, column c-1
  logic wp_left;     // window flag of the row above, column c-2
  logic w_left;      // window flag of this row, column c-2

  // line memories and their prefetched read data
  logic pix_line [MAX_SIDE];
  logic win_line [MAX_SIDE];
  logic p_rd;
  logic wp_rd;

  // result queue
  result_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   fifo_cnt;

  logic               s_acc;
  logic               m_acc;
  logic               pix;
  logic               first_col;
  logic               last_col;
  logic               last_row;
  logic               at_end;
  logic               row_ge2;
  logic               row_ge3;
  logic               wp_cur;
  logic               win;
  logic               miss_a;
  logic               miss_b;
  logic               miss_c;
  logic               miss_d;
  logic               fail_next;
  logic [COUNT_W-1:0] found_next;
  logic [31:0]        win_row_full;
  logic [31:0]        win_col_full;
  result_t            win_res;
  result_t            verdict_res;
  result_t            head;
  logic [1:0]         push_n;

  assign s_acc     = s_tvalid && s_tready;
  assign m_acc     = m_tvalid && m_tready;
  assign s_tready  = (fifo_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
  assign pix       = s_tdata[0];

  assign first_col = (col_cnt == SW'(1));
  assign last_col  = (col_cnt == cols_lim);
  assign last_row  = (row_cnt == rows_lim);
  assign at_end    = last_col && last_row;
  assign row_ge2   = (row_cnt != SW'(1));
  assign row_ge3   = (row_cnt > SW'(2));
  assign wp_cur    = row_ge3 && wp_rd;

  always_comb begin
    win = row_ge2 && !first_col && above_left && p_rd && left_pix && pix;
    // set pixel of the row above, column c-1, against all four windows
    miss_a = row_ge2 && !first_col && above_left && !(wp_left || wp_cur || w_left || win);
    // right edge pixel of the row above
    miss_b = row_ge2 && last_col && p_rd && !(wp_cur || win);
    // bottom row pixel to the left, only windows above it
    miss_c = last_row && !first_col && left_pix && !(w_left || win);
    // bottom right corner pixel
    miss_d = at_end && pix && !win;
    fail_next  = fail || miss_a || miss_b || miss_c || miss_d;
    found_next = found_cnt + COUNT_W'(win);
  end

  assign win_row_full = 32'(row_cnt) - 32'd1;
  assign win_col_full = 32'(col_cnt) - 32'd1;

  always_comb begin
    win_res.kind         = KIND_WINDOW;
    win_res.win_row      = win_row_full[POS_W-1:0];
    win_res.win_col      = win_col_full[POS_W-1:0];
    win_res.covered_ok   = 1'b0;
    win_res.window_count = found_next;
    win_res.last         = 1'b0;

    verdict_res.kind         = KIND_VERDICT;
    verdict_res.win_row      = '0;
    verdict_res.win_col      = '0;
    verdict_res.covered_ok   = !fail_next;
    verdict_res.window_count = found_next;
    verdict_res.last         = 1'b1;

    push_n = s_acc ? (2'(win) + 2'(at_end)) : 2'd0;
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_lim   <= clamp_side(CFG_W'(64));
      cols_lim   <= clamp_side(CFG_W'(64));
      row_cnt    <= SW'(1);
      col_cnt    <= SW'(1);
      found_cnt  <= '0;
      fail       <= 1'b0;
      left_pix   <= 1'b0;
      above_left <= 1'b0;
      wp_left    <= 1'b0;
      w_left     <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_IMAGE_ROWS) begin
        rows_lim <= clamp_side(cfg_data);
      end else begin
        cols_lim <= clamp_side(cfg_data);
      end
      row_cnt    <= SW'(1);
      col_cnt    <= SW'(1);
      found_cnt  <= '0;
      fail       <= 1'b0;
      left_pix   <= 1'b0;
      above_left <= 1'b0;
      wp_left    <= 1'b0;
      w_left     <= 1'b0;
    end else if (s_acc) begin
      if (at_end) begin
        row_cnt    <= SW'(1);
        col_cnt    <= SW'(1);
        found_cnt  <= '0;
        fail       <= 1'b0;
        left_pix   <= 1'b0;
        above_left <= 1'b0;
        wp_left    <= 1'b0;
        w_left     <= 1'b0;
      end else begin
        if (last_col) begin
          row_cnt <= row_cnt + SW'(1);
          col_cnt <= SW'(1);
        end else begin
          col_cnt <= col_cnt + SW'(1);
        end
        found_cnt  <= found_next;
        fail       <= fail_next;
        left_pix   <= pix;
        above_left <= p_rd;
        wp_left    <= first_col ? 1'b0 : wp_cur;
        w_left     <= win;
      end
    end
  end

  // line memories: write this column, prefetch the next one
  always_ff @(posedge clk) begin
    if (s_acc && !cfg_wr_en) begin
      pix_line[AW'(col_cnt - SW'(1))] <= pix;
      if (row_ge2 && !first_col) begin
        win_line[AW'(col_cnt - SW'(2))] <= win;
      end
      p_rd  <= pix_line[last_col ? AW'(0) : AW'(col_cnt)];
      wp_rd <= win_line[last_col ? AW'(0) : AW'(col_cnt - SW'(1))];
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= win ? win_res : verdict_res;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + FIFO_AW'(1)] <= verdict_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      wr_ptr   <= wr_ptr + FIFO_AW'(push_n);
      if (m_acc) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_cnt <= fifo_cnt + FIFO_CW'(push_n) - FIFO_CW'(m_acc);
    end
  end

  assign head      = fifo_mem[rd_ptr];
  assign m_tvalid  = (fifo_cnt != '0);
  assign m_tdata   = {(M_TDATA_W - 2 * POS_W - 1 - COUNT_W)'(0), head.window_count,
                      head.covered_ok, head.win_col, head.win_row};
  assign m_tuser   = head.kind;
  assign m_tlast   = head.last;

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_last_is_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser[0] == KIND_VERDICT)))
    else $error("tlast and result kind disagree");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    (s_acc && at_end && !cfg_wr_en) |=>
      (row_cnt == SW'(1) && col_cnt == SW'(1) && found_cnt == '0 && !fail))
    else $error("stream state not restarted after the last pixel");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (col_cnt >= SW'(1) && col_cnt <= cols_lim && row_cnt >= SW'(1) && row_cnt <= rows_lim))
    else $error("position outside the image");

endmodule

[bench/cover_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cover_result_checker
// Watches the pixel, result and size-write ports of the square cover check
// unit, predicts every window and verdict result on its own copy of the
// line state and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module cover_result_checker
  import bsc_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic [0:0]           m_tuser,
  input  logic                 m_tlast,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fault_count,
  output int                   results_due
);

  localparam int PRINT_CAP = 200;

  logic [CFG_W-1:0]   rows_reg;
  logic [CFG_W-1:0]   cols_reg;
  bit                 above_pix [0:MAX_SIDE+1];
  bit                 above_win [0:MAX_SIDE+1];
  bit                 this_win  [0:MAX_SIDE+1];
  bit                 left_pix;
  int                 next_row;
  int                 next_col;
  logic [COUNT_W-1:0] win_total;
  bit                 uncovered;
  result_t            due_results [$];
  int                 faults = 0;

  function automatic int clamp_side(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  task automatic restart_image();
    for (int i = 0; i <= MAX_SIDE + 1; i++) begin
      above_pix[i] = 1'b0;
      above_win[i] = 1'b0;
      this_win[i]  = 1'b0;
    end
    left_pix  = 1'b0;
    next_row  = 1;
    next_col  = 1;
    win_total = '0;
    uncovered = 1'b0;
  endtask

  task automatic judge_pixel(input bit pix, input bit cov);
    if (pix && !cov) uncovered = 1'b1;
  endtask

  task automatic fold_pixel(input bit p);
    int      nr;
    int      nc;
    int      r;
    int      c;
    bit      w;
    result_t res;
    nr = clamp_side(rows_reg);
    nc = clamp_side(cols_reg);
    r  = (next_row > nr) ? nr : next_row;
    c  = (next_col > nc) ? nc : next_col;

    if (r >= 2 && c >= 2) begin
      w = above_pix[c-1] & above_pix[c] & left_pix & p;
      this_win[c-1] = w;
      if (w) begin
        win_total = win_total + 1'b1;
        res = '{kind: KIND_WINDOW, win_row: POS_W'(r - 1), win_col: POS_W'(c - 1),
                covered_ok: 1'b0, window_count: win_total, last: 1'b0};
        due_results = {due_results, res};
      end
      // pixel above-left is now fully decided
      judge_pixel(above_pix[c-1],
                  above_win[c-2] | above_win[c-1] | this_win[c-2] | this_win[c-1]);
    end
    if (r >= 2 && c == nc)
      judge_pixel(above_pix[nc],
                  above_win[nc-1] | above_win[nc] | this_win[nc-1] | this_win[nc]);
    // bottom row has no window row below it
    if (r == nr && c >= 2) judge_pixel(left_pix, this_win[c-2] | this_win[c-1]);
    if (r == nr && c == nc) judge_pixel(p, this_win[nc-1] | this_win[nc]);

    if (c >= 2) above_pix[c-1] = left_pix;
    if (c == nc) above_pix[nc] = p;
    left_pix = p;

    if (c == nc) begin
      if (r == nr) begin
        res = '{kind: KIND_VERDICT, win_row: '0, win_col: '0, covered_ok: !uncovered,
                window_count: win_total, last: 1'b1};
        due_results = {due_results, res};
        restart_image();
      end else begin
        for (int i = 0; i <= MAX_SIDE + 1; i++) begin
          above_win[i] = this_win[i];
          this_win[i]  = 1'b0;
        end
        next_row = r + 1;
        next_col = 1;
      end
    end else begin
      next_row = r;
      next_col = c + 1;
    end
  endtask

  task automatic report_fault(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    if (faults < PRINT_CAP)
      $display("%0t cover check: %s got %0d want %0d", $realtime, what, got, want);
    faults++;
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      report_fault("result with none due, tdata", m_tdata, 0);
      return;
    end
    want = due_results.pop_front();
    if (m_tuser[0] !== want.kind) report_fault("result_kind", m_tuser[0], want.kind);
    if (m_tdata[5:0] !== want.win_row) report_fault("win_row", m_tdata[5:0], want.win_row);
    if (m_tdata[11:6] !== want.win_col) report_fault("win_col", m_tdata[11:6], want.win_col);
    if (m_tdata[12] !== want.covered_ok)
      report_fault("covered_ok", m_tdata[12], want.covered_ok);
    if (m_tdata[24:13] !== want.window_count)
      report_fault("window_count", m_tdata[24:13], want.window_count);
    if (m_tlast !== want.last) report_fault("last", m_tlast, want.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      restart_image();
      due_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_IMAGE_ROWS) rows_reg = cfg_data;
        else cols_reg = cfg_data;
        restart_image();
      end
      if (s_tvalid && s_tready) fold_pixel(s_tdata[0]);
      if (m_tvalid && m_tready) check_result();
    end
    fault_count <= faults;
    results_due <= due_results.size();
  end

endmodule

[bench/tb_binary_square_cover_check_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_square_cover_check_unit
// Feeds binary images of many sizes through the square cover check unit with
// random gaps on both streams and size changes between images; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_binary_square_cover_check_unit;
  import bsc_pkg::*;

  localparam int MAX_SIDE      = 64;
  localparam int PIXEL_BUDGET  = 1750;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_CYCLES   = 400;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int fault_count;
  int results_due;
  int pixels_sent = 0;
  int quiet_cycles = 0;
  int calm_left = 0;
  int rows_set = 64;
  int cols_set = 64;
  bit frame [0:MAX_SIDE*MAX_SIDE-1];

  binary_square_cover_check_unit #(.MAX_SIDE(MAX_SIDE)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cover_result_checker #(.MAX_SIDE(MAX_SIDE)) result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fault_count (fault_count),
    .results_due (results_due)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int side_of(input int v);
    if (v < 2) return 2;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  task automatic send_pixel(input bit p);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(49) == 0) calm_left = $urandom_range(50, 200);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-1){1'b0}}, p};
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // wait until every result is out, then let the pipeline run empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic idx, input int value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_IMAGE_ROWS) rows_set = value;
    else cols_set = value;
  endtask

  // bits are sent from the highest one down
  task automatic send_pattern(input int n, input logic [15:0] bits);
    for (int i = n - 1; i >= 0; i--) send_pixel(bits[i]);
  endtask

  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) send_pixel(frame[i]);
  endtask

  task automatic build_frame(input int nr, input int nc, input int style);
    int density;
    for (int i = 0; i < nr * nc; i++) frame[i] = 1'b0;
    if (style < 40) begin
      // union of squares, so the opening matches unless a pixel is flipped
      for (int r = 0; r < nr - 1; r++)
        for (int c = 0; c < nc - 1; c++)
          if ($urandom_range(3) == 0) begin
            frame[r*nc + c]       = 1'b1;
            frame[r*nc + c + 1]   = 1'b1;
            frame[(r+1)*nc + c]   = 1'b1;
            frame[(r+1)*nc + c+1] = 1'b1;
          end
      if ($urandom_range(2) == 0) begin
        density = $urandom_range(nr * nc - 1);
        frame[density] = !frame[density];
      end
    end else if (style < 75) begin
      density = $urandom_range(8);
      for (int i = 0; i < nr * nc; i++) frame[i] = ($urandom_range(7) < density);
    end else if (style < 88) begin
      for (int i = 0; i < nr * nc; i++) frame[i] = 1'b1;
    end else if (style < 93) begin
      // stays all zeros
    end else begin
      for (int i = 0; i < nr * nc; i++) frame[i] = 1'b1;
      frame[$urandom_range(nr * nc - 1)] = 1'b0;
    end
  endtask

  task automatic pick_sizes();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) begin
      write_size(CFG_IMAGE_ROWS, $urandom_range(9, 127));
      write_size(CFG_IMAGE_COLS, $urandom_range(0, 4));
    end else if (roll == 1) begin
      write_size(CFG_IMAGE_ROWS, $urandom_range(0, 4));
      write_size(CFG_IMAGE_COLS, $urandom_range(9, 127));
    end else begin
      write_size(CFG_IMAGE_ROWS, $urandom_range(0, 8));
      write_size(CFG_IMAGE_COLS, $urandom_range(0, 8));
    end
  endtask

  // result side: random stalls, one long hold so the input backs up
  initial begin : result_sink
    int gap;
    int burst;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && pixels_sent >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst = ($urandom_range(15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      m_tready <= 1'b1;
      repeat (burst) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("binary_square_cover_check_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int nr;
    int nc;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sizes below the range clamp to a 2x2 image
    write_size(CFG_IMAGE_ROWS, 0);
    write_size(CFG_IMAGE_COLS, 1);
    send_pattern(4, 16'b1111);
    send_pattern(4, 16'b1110);
    send_pattern(4, 16'b0000);
    // size write in the middle of an image drops it
    write_size(CFG_IMAGE_ROWS, 3);
    write_size(CFG_IMAGE_COLS, 3);
    send_pattern(5, 16'b11011);
    write_size(CFG_IMAGE_ROWS, 2);
    send_pattern(6, 16'b110110);

    // tallest and widest images, sizes above the range clamp to the maximum
    write_size(CFG_IMAGE_ROWS, 127);
    write_size(CFG_IMAGE_COLS, 2);
    build_frame(MAX_SIDE, 2, 80);
    send_frame(MAX_SIDE * 2);
    write_size(CFG_IMAGE_ROWS, 2);
    write_size(CFG_IMAGE_COLS, 65);
    build_frame(2, MAX_SIDE, 80);
    send_frame(MAX_SIDE * 2);
    write_size(CFG_IMAGE_ROWS, 64);
    write_size(CFG_IMAGE_COLS, 3);
    build_frame(MAX_SIDE, 3, 10);
    send_frame(MAX_SIDE * 3);

    while (pixels_sent < PIXEL_BUDGET) begin
      if ($urandom_range(9) < 4) pick_sizes();
      nr = side_of(rows_set);
      nc = side_of(cols_set);
      build_frame(nr, nc, $urandom_range(99));
      if ($urandom_range(9) == 0) begin
        send_frame($urandom_range(1, nr * nc - 1));
        write_size($urandom_range(1) ? CFG_IMAGE_ROWS : CFG_IMAGE_COLS,
                   $urandom_range(2, 8));
      end else begin
        send_frame(nr * nc);
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (fault_count == 0 && results_due == 0)
      $display("binary_square_cover_check_unit: match");
    else
      $display("binary_square_cover_check_unit: mismatch");
    $finish;
  end

endmodule
